### design/assert_macros.svh
// Assertion macros shared by the object id link table RTL.
// Define NO_ASSERTIONS to compile every check out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Concurrent check, sampled on the rising clock, off while reset is low
`define OBL_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("obl assertion failed");

// Check that a condition never holds
`define OBL_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("obl forbidden condition");

`else

`define OBL_ASSERT(lbl, clk, rst_n, prop)
`define OBL_NEVER(lbl, clk, rst_n, cond)

`endif

`endif

### design/obl_pkg.sv
// Shared types and codes for the object id link table.
// No dependencies; used by the slot cells, stack cells and top level.
package obl_pkg;

  // Stream payload widths
  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 40;
  localparam int FIELD_HANDLE_W = 32;
  localparam int FIELD_ID_W     = 8;

  // Operation codes carried on in_tuser
  typedef enum logic [1:0] {
    OP_LOOKUP  = 2'd0,
    OP_BIND    = 2'd1,
    OP_REMOVE  = 2'd2,
    OP_REVERSE = 2'd3
  } op_t;

  // Result status codes carried on out_tuser
  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_CREATED = 2'd1,
    ST_MISSING = 2'd2,
    ST_FULL    = 2'd3
  } status_t;

  // Broadcast command to every slot cell
  typedef struct packed {
    logic by_addr;     // match on cell index instead of handle
    logic clear_hits;  // drop the binding of every matching cell
    logic write;       // bind the query handle to the addressed cell
  } slot_cmd_t;

  // Shift command to every free-stack cell
  typedef struct packed {
    logic push;
    logic pop;
  } stk_cmd_t;

endpackage

### design/obl_slot_cell.sv
// One id slot: bound handle, valid bit and a registered match flag.
// Depends on obl_pkg for the slot command struct.
module obl_slot_cell import obl_pkg::*; #(
  parameter int HW   = 32,
  parameter int ID_W = 8,
  parameter int IDX  = 0
) (
  input  logic            clk,
  input  logic            rst_n,
  input  slot_cmd_t       cmd,
  input  logic [ID_W-1:0] wr_id,
  input  logic [HW-1:0]   q_handle,
  input  logic [ID_W-1:0] q_idx,
  output logic            hit_o,
  output logic [HW-1:0]   handle_o
);

  localparam logic [ID_W-1:0] MY_ID = ID_W'(IDX);

  logic          valid_r;
  logic          hit_r;
  logic [HW-1:0] handle_r;
  logic          hit_nxt;

  // Compare this slot against the query
  always_comb begin
    if (cmd.by_addr) begin
      hit_nxt = valid_r && (q_idx == MY_ID);
    end else begin
      hit_nxt = valid_r && (handle_r == q_handle);
    end
  end

  // Hold binding; a write wins over a clear of the same slot
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      hit_r   <= 1'b0;
    end else begin
      hit_r <= hit_nxt;
      if (cmd.write && (wr_id == MY_ID)) begin
        valid_r <= 1'b1;
      end else if (cmd.clear_hits && hit_r) begin
        valid_r <= 1'b0;
      end
    end
  end

  // Handle payload needs no reset: valid gates it everywhere
  always_ff @(posedge clk) begin
    if (cmd.write && (wr_id == MY_ID)) begin
      handle_r <= q_handle;
    end
  end

  assign hit_o    = hit_r;
  assign handle_o = handle_r;

endmodule

### design/obl_stack_cell.sv
// One entry of the free-id stack, built as a shift chain with the top at cell 0.
// Depends on obl_pkg for the stack command struct.
module obl_stack_cell import obl_pkg::*; #(
  parameter int ID_W = 8
) (
  input  logic            clk,
  input  stk_cmd_t        cmd,
  input  logic [ID_W-1:0] up_i,    // neighbor nearer the top, or the pushed id
  input  logic [ID_W-1:0] down_i,  // neighbor farther from the top
  output logic [ID_W-1:0] q_o
);

  logic [ID_W-1:0] data_r;

  // Shift down on push, up on pop
  always_ff @(posedge clk) begin
    if (cmd.push) begin
      data_r <= up_i;
    end else if (cmd.pop) begin
      data_r <= down_i;
    end
  end

  assign q_o = data_r;

endmodule

### design/object_id_link_table_top.sv
// Object id link table: one-to-one map of object handles to small ids.
// Each request passes the slot-cell compare, the registered group reduction and the
//   decide step that updates the cells; a held result stalls the decide step.
//   A new request is taken only after the decide step of the last one.
// Reset: rst_n (sync, active low) clears all bindings, the free count and
//   sets the next fresh id to 1; no clearing pass is needed.
module object_id_link_table_top import obl_pkg::*; #(
  parameter int ID_SLOTS    = 256,
  parameter int HANDLE_BITS = 32
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // [31:0] object_handle, [39:32] link_id, [40] create_if_missing, rest zero
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // [1:0] op
  input  logic [1:0]             in_tuser,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // [7:0] result_id, [39:8] result_handle
  output logic [OUT_TDATA_W-1:0] out_tdata,
  // [1:0] status
  output logic [1:0]             out_tuser
);

`include "assert_macros.svh"

  localparam int ID_W = $clog2(ID_SLOTS);
  localparam int HW   = (HANDLE_BITS < FIELD_HANDLE_W) ? HANDLE_BITS : FIELD_HANDLE_W;
  localparam int GRP  = 16;
  localparam int NG   = (ID_SLOTS + GRP - 1) / GRP;
  localparam int NP   = NG * GRP;
  localparam logic [ID_W:0] SLOTS_CNT = (ID_W + 1)'(ID_SLOTS);

  typedef enum logic [1:0] {S_IDLE, S_CMP, S_GRP, S_DEC} state_t;

  state_t state_r;

  // Query registers
  op_t                   q_op_r;
  logic [HW-1:0]         q_handle_r;
  logic [FIELD_ID_W-1:0] q_lid_r;
  logic                  q_create_r;
  logic [ID_W-1:0]       q_idx;

  // Allocator state
  logic [ID_W:0] free_count_r, free_count_nxt;
  logic [ID_W:0] fresh_r, fresh_nxt;

  // Output register
  logic                  out_valid_r;
  status_t               out_status_r;
  logic [FIELD_ID_W-1:0] out_id_r;
  logic [HW-1:0]         out_handle_r;

  // Cell arrays
  slot_cmd_t       slot_cmd;
  logic [ID_W-1:0] wr_id;
  logic [NP-1:0]   slot_hit;
  logic [HW-1:0]   slot_handle [NP];
  stk_cmd_t        stk_cmd;
  logic [ID_W-1:0] push_id;
  logic [ID_W-1:0] stk_q [ID_SLOTS];

  // Group reduction
  logic            grp_hit_r    [NG];
  logic [ID_W-1:0] grp_id_r     [NG];
  logic [HW-1:0]   grp_handle_r [NG];
  logic            f_hit;
  logic [ID_W-1:0] f_id;
  logic [HW-1:0]   f_handle;

  // Decide step
  logic            fire;
  logic            lid_ok;
  status_t         res_status;
  logic [ID_W-1:0] res_id;
  logic [HW-1:0]   res_handle;

  assign q_idx  = ID_W'(q_lid_r);
  assign lid_ok = (q_lid_r != '0) && (int'(q_lid_r) < ID_SLOTS);

  // Slot cells, padded with empty places up to whole groups
  for (genvar i = 0; i < NP; i++) begin : g_slot
    if (i < ID_SLOTS) begin : g_cell
      obl_slot_cell #(.HW(HW), .ID_W(ID_W), .IDX(i)) u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (slot_cmd),
        .wr_id    (wr_id),
        .q_handle (q_handle_r),
        .q_idx    (q_idx),
        .hit_o    (slot_hit[i]),
        .handle_o (slot_handle[i])
      );
    end else begin : g_pad
      assign slot_hit[i]    = 1'b0;
      assign slot_handle[i] = '0;
    end
  end

  // Free-id stack chain
  for (genvar k = 0; k < ID_SLOTS; k++) begin : g_stk
    logic [ID_W-1:0] up_v, down_v;
    if (k == 0) begin : g_top
      assign up_v = push_id;
    end else begin : g_mid
      assign up_v = stk_q[k-1];
    end
    if (k == ID_SLOTS - 1) begin : g_bot
      assign down_v = '0;
    end else begin : g_nbot
      assign down_v = stk_q[k+1];
    end
    obl_stack_cell #(.ID_W(ID_W)) u_stk (
      .clk    (clk),
      .cmd    (stk_cmd),
      .up_i   (up_v),
      .down_i (down_v),
      .q_o    (stk_q[k])
    );
  end

  // Reduce each group of cell matches into one registered id and handle
  for (genvar g = 0; g < NG; g++) begin : g_grp
    logic            hit_c;
    logic [ID_W-1:0] id_c;
    logic [HW-1:0]   handle_c;
    always_comb begin
      hit_c    = 1'b0;
      id_c     = '0;
      handle_c = '0;
      for (int c = 0; c < GRP; c++) begin
        if (slot_hit[g*GRP + c]) begin
          hit_c    = 1'b1;
          id_c     = id_c | ID_W'(g*GRP + c);
          handle_c = handle_c | slot_handle[g*GRP + c];
        end
      end
    end
    always_ff @(posedge clk) begin
      grp_hit_r[g]    <= hit_c;
      grp_id_r[g]     <= id_c;
      grp_handle_r[g] <= handle_c;
    end
  end

  // Combine the groups
  always_comb begin
    f_hit    = 1'b0;
    f_id     = '0;
    f_handle = '0;
    for (int g = 0; g < NG; g++) begin
      f_hit    = f_hit | grp_hit_r[g];
      f_id     = f_id | grp_id_r[g];
      f_handle = f_handle | grp_handle_r[g];
    end
  end

  assign fire = (state_r == S_DEC) && (!out_valid_r || out_tready);

  // Decide the result and the table update
  always_comb begin
    res_status          = ST_MISSING;
    res_id              = '0;
    res_handle          = '0;
    slot_cmd.by_addr    = (q_op_r == OP_REVERSE);
    slot_cmd.clear_hits = 1'b0;
    slot_cmd.write      = 1'b0;
    wr_id               = q_idx;
    stk_cmd.push        = 1'b0;
    stk_cmd.pop         = 1'b0;
    push_id             = f_id;
    free_count_nxt      = free_count_r;
    fresh_nxt           = fresh_r;
    if (q_op_r == OP_REVERSE) begin
      if (lid_ok && f_hit) begin
        res_status = ST_DONE;
        res_id     = q_idx;
        res_handle = f_handle;
      end
    end else if (q_handle_r != '0) begin
      unique case (q_op_r)
        OP_LOOKUP: begin
          if (f_hit) begin
            res_status = ST_DONE;
            res_id     = f_id;
          end else if (q_create_r) begin
            priority if (free_count_r != '0) begin
              res_status     = ST_CREATED;
              res_id         = stk_q[0];
              stk_cmd.pop    = fire;
              free_count_nxt = free_count_r - 1'b1;
            end else if (fresh_r < SLOTS_CNT) begin
              res_status = ST_CREATED;
              res_id     = ID_W'(fresh_r);
              fresh_nxt  = fresh_r + 1'b1;
            end else begin
              res_status = ST_FULL;
            end
            wr_id          = res_id;
            slot_cmd.write = fire && (res_status == ST_CREATED);
          end
        end
        OP_BIND: begin
          if (lid_ok) begin
            res_status          = ST_DONE;
            res_id              = q_idx;
            slot_cmd.clear_hits = fire;
            slot_cmd.write      = fire;
          end
        end
        OP_REMOVE: begin
          if (f_hit) begin
            res_status          = ST_DONE;
            res_id              = f_id;
            slot_cmd.clear_hits = fire;
            if (free_count_r < SLOTS_CNT) begin
              stk_cmd.push   = fire;
              free_count_nxt = free_count_r + 1'b1;
            end
          end
        end
        default: begin
          res_status = ST_MISSING;
        end
      endcase
    end
  end

  // Sequencer, allocator counters and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_valid_r  <= 1'b0;
      out_status_r <= ST_DONE;
      out_id_r     <= '0;
      out_handle_r <= '0;
      free_count_r <= '0;
      fresh_r      <= (ID_W + 1)'(1);
      q_op_r       <= OP_LOOKUP;
      q_handle_r   <= '0;
      q_lid_r      <= '0;
      q_create_r   <= 1'b0;
    end else begin
      // Load a new result, or drop the old one after its transfer
      if (fire) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            q_op_r     <= op_t'(in_tuser);
            q_handle_r <= in_tdata[HW-1:0];
            q_lid_r    <= in_tdata[39:32];
            q_create_r <= in_tdata[40];
            state_r    <= S_CMP;
          end
        end
        S_CMP: state_r <= S_GRP;
        S_GRP: state_r <= S_DEC;
        S_DEC: begin
          if (fire) begin
            out_status_r <= res_status;
            out_id_r     <= FIELD_ID_W'(res_id);
            out_handle_r <= res_handle;
            free_count_r <= free_count_nxt;
            fresh_r      <= fresh_nxt;
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = {FIELD_HANDLE_W'(out_handle_r), out_id_r};

  // Table stays one-to-one: at most one slot matches any query
  `OBL_ASSERT(a_one_hit, clk, rst_n, $onehot0(slot_hit))
  // Free count and fresh id stay within the id space
  `OBL_ASSERT(a_count_rng, clk, rst_n, (free_count_r <= SLOTS_CNT) && (fresh_r != '0))
  `OBL_ASSERT(a_fresh_rng, clk, rst_n, fresh_r <= SLOTS_CNT)
  // Never pop an empty stack
  `OBL_NEVER(a_pop_empty, clk, rst_n, stk_cmd.pop && (free_count_r == '0))
  // A miss carries neither id nor handle
  `OBL_ASSERT(a_miss_zero, clk, rst_n,
              (out_tvalid && (out_tuser == ST_MISSING)) |-> (out_tdata == '0))

endmodule

### verif/obl_link_checker.sv
// Scoreboard for the object id link table: watches both stream channels,
// predicts each result from its own copy of the table and compares.
// Depends on obl_pkg for the op and status codes.
`timescale 1ns / 1ps

module obl_link_checker import obl_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  input  logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  input  logic [1:0]             in_tuser,
  input  logic                   out_tvalid,
  input  logic                   out_tready,
  input  logic [OUT_TDATA_W-1:0] out_tdata,
  input  logic [1:0]             out_tuser,
  output int                     fail_count,
  output int                     pending_results,
  output int                     results_seen,
  output int                     full_seen
);

  localparam int SLOT_COUNT = 256;

  typedef struct packed {
    status_t     status;
    logic [7:0]  id;
    logic [31:0] handle;
  } link_answer_t;

  // Shadow copy of the table
  logic [31:0]  slot_handle [SLOT_COUNT];
  logic         slot_live   [SLOT_COUNT];
  logic [7:0]   freed_ids   [SLOT_COUNT];
  int           freed_depth;
  int           fresh_id;
  link_answer_t answers_due [$];

  // Lowest live id holding the handle, 0 when none
  function automatic int find_slot(logic [31:0] h);
    for (int i = 1; i < SLOT_COUNT; i++)
      if (slot_live[i] && slot_handle[i] == h) return i;
    return 0;
  endfunction

  // Apply one request to the shadow table and return its answer
  function automatic link_answer_t resolve_request(op_t op, logic [31:0] h,
                                                   logic [7:0] lid, logic grow);
    link_answer_t ans;
    int           slot;
    ans.status = ST_MISSING;
    ans.id     = 8'd0;
    ans.handle = 32'd0;
    if (op == OP_REVERSE) begin
      if (lid != 0 && int'(lid) < SLOT_COUNT && slot_live[lid]) begin
        ans.status = ST_DONE;
        ans.id     = lid;
        ans.handle = slot_handle[lid];
      end
      return ans;
    end
    // Handle zero never touches the table
    if (h == 32'd0) return ans;
    case (op)
      OP_LOOKUP: begin
        slot = find_slot(h);
        if (slot != 0) begin
          ans.status = ST_DONE;
          ans.id     = slot[7:0];
        end else if (grow) begin
          // Reuse the most recently freed id, else take a fresh one
          if (freed_depth > 0) begin
            freed_depth--;
            slot = int'(freed_ids[freed_depth]);
          end else if (fresh_id < SLOT_COUNT) begin
            slot = fresh_id;
            fresh_id++;
          end else begin
            ans.status = ST_FULL;
            return ans;
          end
          slot_handle[slot] = h;
          slot_live[slot]   = 1'b1;
          ans.status = ST_CREATED;
          ans.id     = slot[7:0];
        end
      end
      OP_BIND: begin
        if (lid == 0 || int'(lid) >= SLOT_COUNT) return ans;
        // Drop any older binding of the same object first
        for (int i = 1; i < SLOT_COUNT; i++)
          if (slot_live[i] && slot_handle[i] == h) begin
            slot_live[i]   = 1'b0;
            slot_handle[i] = 32'd0;
          end
        slot_handle[lid] = h;
        slot_live[lid]   = 1'b1;
        ans.status = ST_DONE;
        ans.id     = lid;
      end
      default: begin
        slot = find_slot(h);
        if (slot == 0) return ans;
        slot_live[slot]   = 1'b0;
        slot_handle[slot] = 32'd0;
        // A push onto a full stack is lost
        if (freed_depth < SLOT_COUNT) begin
          freed_ids[freed_depth] = slot[7:0];
          freed_depth++;
        end
        ans.status = ST_DONE;
        ans.id     = slot[7:0];
      end
    endcase
    return ans;
  endfunction

  always @(posedge clk) begin
    link_answer_t want;
    if (!rst_n) begin
      for (int i = 0; i < SLOT_COUNT; i++) begin
        slot_handle[i] = 32'd0;
        slot_live[i]   = 1'b0;
      end
      freed_depth     = 0;
      fresh_id        = 1;
      fail_count      = 0;
      results_seen    = 0;
      full_seen       = 0;
      answers_due.delete();
      pending_results = 0;
    end else begin
      // Check a result transfer against the oldest answer due
      if (out_tvalid && out_tready) begin
        results_seen++;
        if (out_tuser == ST_FULL) full_seen++;
        if (answers_due.size() == 0) begin
          $error("result with no request outstanding: status %0d id %0d handle %h",
                 out_tuser, out_tdata[7:0], out_tdata[39:8]);
          fail_count++;
        end else begin
          want = answers_due.pop_front();
          if (out_tuser != want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_tuser);
            fail_count++;
          end
          if (out_tdata[7:0] != want.id) begin
            $error("result_id: expected %0d, got %0d", want.id, out_tdata[7:0]);
            fail_count++;
          end
          if (out_tdata[39:8] != want.handle) begin
            $error("result_handle: expected %h, got %h", want.handle, out_tdata[39:8]);
            fail_count++;
          end
        end
      end
      // Predict the answer of a request transfer
      if (in_tvalid && in_tready)
        answers_due.insert(answers_due.size(),
                           resolve_request(op_t'(in_tuser), in_tdata[31:0],
                                           in_tdata[39:32], in_tdata[40]));
      pending_results = answers_due.size();
    end
  end

endmodule

### verif/tb_object_id_link_table_top.sv
// Testbench top for the object id link table: drives request streams,
// stalls the result side and reports the verdict.
// Depends on obl_pkg, object_id_link_table_top and obl_link_checker.
`timescale 1ns / 1ps

module tb_object_id_link_table_top;
  import obl_pkg::*;

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic [1:0]             in_tuser;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [1:0]             out_tuser;

  int fail_count;
  int pending_results;
  int results_seen;
  int full_seen;
  int requests_sent;
  bit bursts_on;

  logic [31:0] handle_pool [32];
  logic [31:0] created_handles [$];

  object_id_link_table_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  obl_link_checker checker_i (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .in_tuser       (in_tuser),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .out_tuser      (out_tuser),
    .fail_count     (fail_count),
    .pending_results(pending_results),
    .results_seen   (results_seen),
    .full_seen      (full_seen)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop in case the block hangs
  initial begin
    #2_000_000;
    $display("FAILURE");
    $finish;
  end

  // Result side: random short stalls while bursts are enabled
  initial begin
    out_tready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (bursts_on && $urandom_range(0, 5) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 3)) @(negedge clk);
      end
      out_tready <= 1'b1;
    end
  end

  // Present one request and hold it until the transfer; returns at a falling edge
  task automatic issue_request(op_t op, logic [31:0] h, logic [7:0] lid, logic grow);
    if (bursts_on && $urandom_range(0, 4) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {7'd0, grow, lid, h};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    requests_sent++;
    if (op == OP_LOOKUP && grow) created_handles.insert(created_handles.size(), h);
    @(negedge clk);
  endtask

  // Hold off the sender until every result is back
  task automatic drain_results();
    in_tvalid <= 1'b0;
    wait (pending_results == 0);
    @(negedge clk);
  endtask

  function automatic logic [31:0] pick_created();
    if (created_handles.size() == 0) return $urandom;
    return created_handles[$urandom_range(0, created_handles.size() - 1)];
  endfunction

  initial begin
    op_t         op;
    logic [31:0] h;
    logic [7:0]  lid;
    int          roll;
    int          fill_count;

    in_tvalid     = 1'b0;
    in_tdata      = '0;
    in_tuser      = OP_LOOKUP;
    rst_n         = 1'b0;
    bursts_on     = 1'b1;
    requests_sent = 0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: none values, id 0 and the top id 255, rebinding and id recycling
    issue_request(OP_REVERSE, 32'd0, 8'd0, 1'b0);
    issue_request(OP_REVERSE, 32'd0, 8'd255, 1'b0);
    issue_request(OP_LOOKUP, 32'd0, 8'd0, 1'b1);
    issue_request(OP_BIND, 32'd0, 8'd5, 1'b0);
    issue_request(OP_REMOVE, 32'd0, 8'd0, 1'b0);
    issue_request(OP_LOOKUP, 32'hFFFF_FFFF, 8'd0, 1'b0);
    issue_request(OP_LOOKUP, 32'hFFFF_FFFF, 8'd0, 1'b1);
    issue_request(OP_LOOKUP, 32'hFFFF_FFFF, 8'hAA, 1'b1);
    issue_request(OP_LOOKUP, 32'h0000_0001, 8'd0, 1'b1);
    issue_request(OP_BIND, 32'hFFFF_FFFF, 8'd255, 1'b0);
    issue_request(OP_REVERSE, 32'd0, 8'd255, 1'b0);
    issue_request(OP_REVERSE, 32'd0, 8'd1, 1'b0);
    issue_request(OP_BIND, 32'h0000_0001, 8'd0, 1'b0);
    issue_request(OP_BIND, 32'h0000_0001, 8'd255, 1'b0);
    issue_request(OP_REMOVE, 32'hFFFF_FFFF, 8'd0, 1'b0);
    issue_request(OP_REMOVE, 32'h0000_0001, 8'd0, 1'b0);
    issue_request(OP_LOOKUP, 32'hA5A5_5A5A, 8'd0, 1'b1);
    // Bind ahead of the fresh counter, then let allocation take that slot over
    issue_request(OP_BIND, 32'h0000_1234, 8'd3, 1'b0);
    issue_request(OP_LOOKUP, 32'h0000_5555, 8'd0, 1'b1);
    issue_request(OP_LOOKUP, 32'h0000_1234, 8'd0, 1'b0);
    issue_request(OP_REVERSE, 32'h0000_1234, 8'd3, 1'b1);
    issue_request(OP_REVERSE, 32'hDEAD_BEEF, 8'hFF, 1'b1);
    drain_results();

    // Random mix over a small handle set so lookups hit
    handle_pool[0] = 32'hFFFF_FFFF;
    handle_pool[1] = 32'h0000_0001;
    for (int i = 2; i < 32; i++) handle_pool[i] = $urandom;
    for (int n = 0; n < 100; n++) begin
      op   = op_t'($urandom_range(0, 3));
      roll = $urandom_range(0, 19);
      if (roll == 0) h = 32'd0;
      else if (roll == 1) h = $urandom;
      else h = handle_pool[$urandom_range(0, 31)];
      lid = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 255))
                                        : 8'($urandom_range(1, 40));
      issue_request(op, h, lid, $urandom_range(0, 9) < 7);
    end
    drain_results();

    // Fill the table with fresh objects until it reports full a few times
    fill_count = 0;
    while (full_seen < 4 && fill_count < 330) begin
      if ($urandom_range(0, 15) == 0)
        issue_request(OP_REVERSE, $urandom, 8'($urandom_range(1, 255)), 1'b0);
      else
        issue_request(OP_LOOKUP, $urandom, 8'($urandom), 1'b1);
      fill_count++;
    end
    drain_results();

    // Last stretch without idling: free, reuse, rebind and reverse lookups
    bursts_on = 1'b0;
    for (int n = 0; n < 60; n++) begin
      roll = $urandom_range(0, 19);
      if (roll < 8)
        issue_request(OP_REMOVE, pick_created(), 8'($urandom), 1'b0);
      else if (roll < 14)
        issue_request(OP_LOOKUP, (roll < 11) ? pick_created() : $urandom,
                      8'($urandom), 1'b1);
      else if (roll < 17)
        issue_request(OP_REVERSE, $urandom, 8'($urandom_range(0, 255)), 1'b0);
      else
        issue_request(OP_BIND, pick_created(), 8'($urandom_range(0, 255)), 1'b0);
    end
    in_tvalid <= 1'b0;

    wait (pending_results == 0);
    repeat (10) @(negedge clk);

    $display("Sent %0d requests over all four operations, including none values,",
             requests_sent);
    $display("id recycling and table exhaustion; %0d results checked, %0d table-full.",
             results_seen, full_seen);
    if (fail_count == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule

### sim.f
+incdir+design
design/obl_pkg.sv
design/obl_slot_cell.sv
design/obl_stack_cell.sv
design/object_id_link_table_top.sv
verif/obl_link_checker.sv
verif/tb_object_id_link_table_top.sv
